>>> rtl/core/leb_pkg.sv
// ----------------------------------------------------------------------------
// leb_pkg: shared types and constants for the line edit buffer
// sizes of the text store, edit event codes and the bundles that pass
// between the sequencer, the text store and the top level
// ----------------------------------------------------------------------------
package leb_pkg;

    // store depth, one entry is kept spare so capacity is TEXT_MAX-1 bytes
    localparam int TEXT_MAX = 256;
    localparam int LEN_W    = $clog2(TEXT_MAX);
    localparam int CMP_W    = (LEN_W > 8) ? LEN_W : 8;

    // printable range accepted by insert
    localparam logic [7:0] CH_LOW  = 8'h20;
    localparam logic [7:0] CH_HIGH = 8'h7E;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    typedef logic [LEN_W-1:0] t_len;

    typedef enum logic [3:0] {
        M_BEGIN  = 4'd0,
        M_LOAD   = 4'd1,
        M_INSERT = 4'd2,
        M_BKSP   = 4'd3,
        M_DELETE = 4'd4,
        M_ENTER  = 4'd5,
        M_CANCEL = 4'd6,
        M_LEFT   = 4'd7,
        M_RIGHT  = 4'd8,
        M_HOME   = 4'd9,
        M_END    = 4'd10,
        M_STOP   = 4'd11,
        M_READ   = 4'd12,
        M_POLL   = 4'd13
    } t_mode;

    // one write and one read port request towards the text store
    typedef struct packed {
        logic       we;
        t_len       wa;
        logic [7:0] wd;
        t_len       ra;
    } t_mem_req;

    // result beat, lowest field in the lowest bits
    typedef struct packed {
        logic [7:0] read_byte;
        logic       submit_seen;
        logic       is_active;
        logic [7:0] cursor_pos;
        logic [7:0] text_length;
    } t_result;

endpackage

>>> rtl/core/leb_store.sv
// ----------------------------------------------------------------------------
// leb_store: text byte store
// single write port and a single read port with registered read data
// ----------------------------------------------------------------------------
module leb_store (
    input  logic              i_clk,
    input  leb_pkg::t_mem_req i_req,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [leb_pkg::TEXT_MAX];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.wa] <= i_req.wd;
        end
        r_rdata <= r_mem[i_req.ra];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/leb_ctrl.sv
// ----------------------------------------------------------------------------
// leb_ctrl: edit sequencer
// holds length, cursor and flags, decodes each edit event and walks the
// tail of the text one byte per cycle through the store port on shifts
// ----------------------------------------------------------------------------
module leb_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  leb_pkg::t_mode       i_mode,
    input  logic [7:0]           i_ch,
    input  logic [7:0]           i_idx,
    input  logic [7:0]           i_rdata,
    input  logic                 i_take,
    output logic                 o_ready,
    output logic                 o_done,
    output leb_pkg::t_result     o_res,
    output leb_pkg::t_mem_req    o_mem
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SHIFT  = 5'b00010,
        ST_PUT    = 5'b00100,
        ST_RDWAIT = 5'b01000,
        ST_DONE   = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    leb_pkg::t_len r_len, n_len;
    leb_pkg::t_len r_cur, n_cur;
    logic          r_act, n_act;
    logic          r_sub, n_sub;
    logic          r_seen, n_seen;
    logic [7:0]    r_rbyte, n_rbyte;
    leb_pkg::t_len r_src, n_src;
    leb_pkg::t_len r_dst, n_dst;
    leb_pkg::t_len r_left, n_left;
    logic          r_up, n_up;
    logic          r_ins, n_ins;
    leb_pkg::t_len r_put_addr, n_put_addr;
    logic [7:0]    r_put_ch, n_put_ch;

    logic full;
    logic idx_ok;
    logic ch_print;

    assign full     = r_len >= leb_pkg::t_len'(leb_pkg::TEXT_MAX - 1);
    assign idx_ok   = leb_pkg::CMP_W'(i_idx) < leb_pkg::CMP_W'(r_len);
    assign ch_print = (i_ch >= leb_pkg::CH_LOW) && (i_ch <= leb_pkg::CH_HIGH);

    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_cur      = r_cur;
        n_act      = r_act;
        n_sub      = r_sub;
        n_seen     = r_seen;
        n_rbyte    = r_rbyte;
        n_src      = r_src;
        n_dst      = r_dst;
        n_left     = r_left;
        n_up       = r_up;
        n_ins      = r_ins;
        n_put_addr = r_put_addr;
        n_put_ch   = r_put_ch;
        o_mem.we   = 1'b0;
        o_mem.wa   = r_dst;
        o_mem.wd   = i_rdata;
        o_mem.ra   = r_src;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_DONE;
                    n_seen  = 1'b0;
                    n_rbyte = 8'd0;
                    unique case (i_mode)
                        leb_pkg::M_BEGIN: begin
                            n_len = '0;
                            n_cur = '0;
                            n_act = 1'b1;
                            n_sub = 1'b0;
                        end
                        leb_pkg::M_LOAD: begin
                            if (r_act && i_ch != 8'd0 && !full) begin
                                o_mem.we = 1'b1;
                                o_mem.wa = r_len;
                                o_mem.wd = i_ch;
                                n_len    = r_len + 1'b1;
                                n_cur    = r_len + 1'b1;
                            end
                        end
                        leb_pkg::M_INSERT: begin
                            if (r_act && ch_print && !full) begin
                                n_len = r_len + 1'b1;
                                n_cur = r_cur + 1'b1;
                                if (r_cur == r_len) begin
                                    o_mem.we = 1'b1;
                                    o_mem.wa = r_cur;
                                    o_mem.wd = i_ch;
                                end else begin
                                    // tail moves up by one, from the end down
                                    o_mem.ra   = r_len - 1'b1;
                                    n_src      = r_len - 2'd2;
                                    n_dst      = r_len;
                                    n_left     = r_len - r_cur;
                                    n_up       = 1'b0;
                                    n_ins      = 1'b1;
                                    n_put_addr = r_cur;
                                    n_put_ch   = i_ch;
                                    n_state    = ST_SHIFT;
                                end
                            end
                        end
                        leb_pkg::M_BKSP: begin
                            if (r_act && r_cur != '0) begin
                                n_len = r_len - 1'b1;
                                n_cur = r_cur - 1'b1;
                                if (r_cur != r_len) begin
                                    o_mem.ra = r_cur;
                                    n_src    = r_cur + 1'b1;
                                    n_dst    = r_cur - 1'b1;
                                    n_left   = r_len - r_cur;
                                    n_up     = 1'b1;
                                    n_ins    = 1'b0;
                                    n_state  = ST_SHIFT;
                                end
                            end
                        end
                        leb_pkg::M_DELETE: begin
                            if (r_act && r_cur < r_len) begin
                                n_len = r_len - 1'b1;
                                if (r_cur + 1'b1 != r_len) begin
                                    o_mem.ra = r_cur + 1'b1;
                                    n_src    = r_cur + 2'd2;
                                    n_dst    = r_cur;
                                    n_left   = r_len - r_cur - 1'b1;
                                    n_up     = 1'b1;
                                    n_ins    = 1'b0;
                                    n_state  = ST_SHIFT;
                                end
                            end
                        end
                        leb_pkg::M_ENTER: begin
                            if (r_act) begin
                                n_sub = 1'b1;
                                n_act = 1'b0;
                            end
                        end
                        leb_pkg::M_CANCEL: begin
                            if (r_act) begin
                                n_len = '0;
                                n_cur = '0;
                                n_act = 1'b0;
                            end
                        end
                        leb_pkg::M_LEFT: begin
                            if (r_act && r_cur != '0) begin
                                n_cur = r_cur - 1'b1;
                            end
                        end
                        leb_pkg::M_RIGHT: begin
                            if (r_act && r_cur < r_len) begin
                                n_cur = r_cur + 1'b1;
                            end
                        end
                        leb_pkg::M_HOME: begin
                            if (r_act) begin
                                n_cur = '0;
                            end
                        end
                        leb_pkg::M_END: begin
                            if (r_act) begin
                                n_cur = r_len;
                            end
                        end
                        leb_pkg::M_STOP: begin
                            n_act = 1'b0;
                        end
                        leb_pkg::M_READ: begin
                            if (idx_ok) begin
                                o_mem.ra = leb_pkg::t_len'(i_idx);
                                n_state  = ST_RDWAIT;
                            end
                        end
                        leb_pkg::M_POLL: begin
                            n_seen = r_sub;
                            n_sub  = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SHIFT: begin
                // write the byte read last cycle, fetch the next one
                o_mem.we = 1'b1;
                n_dst    = r_up ? r_dst + 1'b1 : r_dst - 1'b1;
                n_src    = r_up ? r_src + 1'b1 : r_src - 1'b1;
                n_left   = r_left - 1'b1;
                if (r_left == leb_pkg::t_len'(1)) begin
                    n_state = r_ins ? ST_PUT : ST_DONE;
                end
            end
            ST_PUT: begin
                o_mem.we = 1'b1;
                o_mem.wa = r_put_addr;
                o_mem.wd = r_put_ch;
                n_state  = ST_DONE;
            end
            ST_RDWAIT: begin
                n_rbyte = i_rdata;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_len   <= '0;
            r_cur   <= '0;
            r_act   <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_cur   <= n_cur;
            r_act   <= n_act;
            r_sub   <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seen     <= n_seen;
        r_rbyte    <= n_rbyte;
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_left     <= n_left;
        r_up       <= n_up;
        r_ins      <= n_ins;
        r_put_addr <= n_put_addr;
        r_put_ch   <= n_put_ch;
    end

    assign o_ready           = (r_state == ST_IDLE);
    assign o_done            = (r_state == ST_DONE);
    assign o_res.text_length = 8'(r_len);
    assign o_res.cursor_pos  = 8'(r_cur);
    assign o_res.is_active   = r_act;
    assign o_res.submit_seen = r_seen;
    assign o_res.read_byte   = r_rbyte;

endmodule

>>> rtl/core/line_edit_buffer.sv
// ----------------------------------------------------------------------------
// line_edit_buffer: single-line text edit buffer with a cursor
// one edit event per input beat, one status beat out per event
// ----------------------------------------------------------------------------
// Each input beat is one edit event (begin, load, insert, backspace, delete,
// enter, cancel, cursor moves, stop, read, poll) and returns exactly one
// result beat with the length, cursor and flags after the event. Most events
// pass the sequencer's done state and then the output register before their
// result beat is handed over; a read first also waits for the registered
// store read. Insert, backspace and delete move the bytes behind the cursor
// through the single store port one byte per cycle, and an insert before the
// end then writes the new byte. The longest event is an insert at the start
// of a text of TEXT_MAX-2 bytes. The input is not ready while an event is in
// work, but a new event is taken while the previous result beat still waits
// in the output register. The store holds TEXT_MAX-1 bytes.
// ----------------------------------------------------------------------------
module line_edit_buffer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [3:0]                     s_axis_tuser,  // mode
    input  logic [leb_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // char_in, read_index
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // text_length, cursor_pos, is_active, submit_seen, read_byte, zero pad
    output logic [leb_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic                            ready;
    logic                            done;
    logic                            take;
    logic [7:0]                      rdata;
    leb_pkg::t_result                res;
    leb_pkg::t_mem_req               mem_req;
    logic                            r_ovalid;
    logic [leb_pkg::OUT_DATA_W-1:0]  r_odata;

    // output slot is free when empty or being drained this cycle
    assign take = !r_ovalid || m_axis_tready;

    leb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_mode  (leb_pkg::t_mode'(s_axis_tuser)),
        .i_ch    (s_axis_tdata[7:0]),
        .i_idx   (s_axis_tdata[15:8]),
        .i_rdata (rdata),
        .i_take  (take),
        .o_ready (ready),
        .o_done  (done),
        .o_res   (res),
        .o_mem   (mem_req)
    );

    leb_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    // result register, parts the sequencer from the output side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (done && take) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done && take) begin
            r_odata <= leb_pkg::OUT_DATA_W'(res);
        end
    end

    assign s_axis_tready = ready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

>>> rtl/core/leb_checker.sv
// ----------------------------------------------------------------------------
// leb_checker: port level checks for the line edit buffer
// watches the stream ports only, attached to the top level by bind
// ----------------------------------------------------------------------------
module leb_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [leb_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // one event at a time: no input beat right after an accepted one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready straight after an accepted beat");

    // cursor never passes the end of the text
    a_cursor_in_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:8] <= m_axis_tdata[7:0])
        else $error("cursor beyond text length");

    // a pending submit only exists in a closed session
    a_seen_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[17] |-> !m_axis_tdata[16])
        else $error("submit seen while session active");

endmodule

bind line_edit_buffer leb_checker u_leb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> bench/tb_line_edit_buffer.sv
// ----------------------------------------------------------------------------
// tb_line_edit_buffer: self-checking bench for the line edit buffer
// drives edit events as input beats and keeps its own model of the text,
// cursor and flags; every status beat is checked field by field against
// the oldest expected status, with random idling on both stream sides
// ----------------------------------------------------------------------------
module tb_line_edit_buffer;

    // spare mode codes, the block reports its state and does nothing else
    localparam logic [3:0] MODE_SPARE_A = 4'd14;
    localparam logic [3:0] MODE_SPARE_B = 4'd15;

    localparam int RES_W      = $bits(leb_pkg::t_result);
    localparam int SETTLE_CYC = leb_pkg::TEXT_MAX + 16;  // longest tail shift plus margin

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [3:0]                     s_axis_tuser;   // mode
    logic [leb_pkg::IN_DATA_W-1:0]  s_axis_tdata;   // char_in, read_index
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    // text_length, cursor_pos, is_active, submit_seen, read_byte, zero pad
    logic [leb_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    line_edit_buffer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // model of the edit buffer
    logic [7:0] txt_store [leb_pkg::TEXT_MAX];
    int         txt_len;
    int         txt_cursor;
    bit         txt_active;
    bit         txt_submitted;

    leb_pkg::t_result status_q [$];   // expected status beats, oldest first

    // run control shared between the sender, the sink and the tests
    bit sender_gaps;
    bit sink_stalls;
    int sink_hold_req;

    int mismatches;
    int events_sent;
    int beats_checked;
    int peak_len;
    int full_hits;
    int mode_hits [16];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("%0t: run did not complete in time", $time);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // model: works out the status beat for one accepted event
    // ------------------------------------------------------------------
    function automatic leb_pkg::t_result apply_edit(logic [3:0] mode, logic [7:0] ch,
                                                    logic [7:0] idx);
        leb_pkg::t_result r;
        int               i;
        bit               full;
        r    = '0;
        full = (txt_len >= leb_pkg::TEXT_MAX - 1);
        case (mode)
            leb_pkg::M_BEGIN: begin
                txt_len       = 0;
                txt_cursor    = 0;
                txt_active    = 1'b1;
                txt_submitted = 1'b0;
            end
            leb_pkg::M_LOAD: begin
                // raw append, any nonzero byte
                if (txt_active && ch != 8'h00 && !full) begin
                    txt_store[leb_pkg::t_len'(txt_len)] = ch;
                    txt_len++;
                    txt_cursor = txt_len;
                end
            end
            leb_pkg::M_INSERT: begin
                if (txt_active && ch >= leb_pkg::CH_LOW && ch <= leb_pkg::CH_HIGH
                        && !full) begin
                    for (i = txt_len; i > txt_cursor; i--)
                        txt_store[leb_pkg::t_len'(i)] = txt_store[leb_pkg::t_len'(i-1)];
                    txt_store[leb_pkg::t_len'(txt_cursor)] = ch;
                    txt_cursor++;
                    txt_len++;
                end
            end
            leb_pkg::M_BKSP: begin
                if (txt_active && txt_cursor > 0) begin
                    for (i = txt_cursor; i < txt_len; i++)
                        txt_store[leb_pkg::t_len'(i-1)] = txt_store[leb_pkg::t_len'(i)];
                    txt_cursor--;
                    txt_len--;
                end
            end
            leb_pkg::M_DELETE: begin
                if (txt_active && txt_cursor < txt_len) begin
                    for (i = txt_cursor + 1; i < txt_len; i++)
                        txt_store[leb_pkg::t_len'(i-1)] = txt_store[leb_pkg::t_len'(i)];
                    txt_len--;
                end
            end
            leb_pkg::M_ENTER: begin
                if (txt_active) begin
                    txt_submitted = 1'b1;
                    txt_active    = 1'b0;
                end
            end
            leb_pkg::M_CANCEL: begin
                if (txt_active) begin
                    txt_len    = 0;
                    txt_cursor = 0;
                    txt_active = 1'b0;
                end
            end
            leb_pkg::M_LEFT: begin
                if (txt_active && txt_cursor > 0) txt_cursor--;
            end
            leb_pkg::M_RIGHT: begin
                if (txt_active && txt_cursor < txt_len) txt_cursor++;
            end
            leb_pkg::M_HOME: begin
                if (txt_active) txt_cursor = 0;
            end
            leb_pkg::M_END: begin
                if (txt_active) txt_cursor = txt_len;
            end
            leb_pkg::M_STOP: begin
                txt_active = 1'b0;
            end
            leb_pkg::M_READ: begin
                if (int'(idx) < txt_len) r.read_byte = txt_store[leb_pkg::t_len'(idx)];
            end
            leb_pkg::M_POLL: begin
                r.submit_seen = txt_submitted;
                txt_submitted = 1'b0;
            end
            default: begin
            end
        endcase
        r.text_length = txt_len[7:0];
        r.cursor_pos  = txt_cursor[7:0];
        r.is_active   = txt_active;
        if (txt_len > peak_len) peak_len = txt_len;
        if (txt_len >= leb_pkg::TEXT_MAX - 1) full_hits++;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want,
                                        logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // status checker, samples at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        leb_pkg::t_result want;
        leb_pkg::t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[RES_W-1:0];
            if (status_q.size() == 0) begin
                $display("%0t: unexpected status beat, expected none, actual 0x%0h",
                         $time, m_axis_tdata);
                mismatches++;
            end else begin
                want = status_q.pop_front();
                beats_checked++;
                check_field("text_length", 32'(want.text_length), 32'(got.text_length));
                check_field("cursor_pos",  32'(want.cursor_pos),  32'(got.cursor_pos));
                check_field("is_active",   32'(want.is_active),   32'(got.is_active));
                check_field("submit_seen", 32'(want.submit_seen), 32'(got.submit_seen));
                check_field("read_byte",   32'(want.read_byte),   32'(got.read_byte));
                check_field("pad", '0, 32'(m_axis_tdata[leb_pkg::OUT_DATA_W-1:RES_W]));
            end
        end
    end

    // ------------------------------------------------------------------
    // sink side: short random stalls, or a long hold when a test asks
    // ------------------------------------------------------------------
    initial begin
        int hold_left;
        int stall_left;
        hold_left     = 0;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (sink_hold_req > 0) begin
                hold_left     = sink_hold_req;
                sink_hold_req = 0;
            end
            if (hold_left > 0) begin
                m_axis_tready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
                m_axis_tready = 1'b0;
                stall_left    = $urandom_range(1, 4) - 1;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // sender: offers one event beat, called at a falling edge
    // ------------------------------------------------------------------
    task automatic send_event(logic [3:0] mode, logic [7:0] ch, logic [7:0] idx);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = mode;
        s_axis_tdata  = {idx, ch};
        do @(posedge i_clk); while (!s_axis_tready);
        status_q.push_back(apply_edit(mode, ch, idx));
        events_sent++;
        mode_hits[mode]++;
        @(negedge i_clk);
        // valid stays high into the next beat unless a gap is taken here
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_index();
        if (txt_len > 0 && $urandom_range(0, 4) != 0)
            return 8'($urandom_range(0, txt_len - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_printable();
        if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(32'(leb_pkg::CH_LOW), 32'(leb_pkg::CH_HIGH)));
    endfunction

    // one session: begin, preset by loads, random edits, then a close
    task automatic run_session(int max_load, int n_edits);
        int         k;
        int         pick;
        logic [7:0] b;
        send_event(leb_pkg::M_BEGIN, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, max_load)) begin
            b = ($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
            send_event(leb_pkg::M_LOAD, b, 8'($urandom_range(0, 255)));
        end
        for (k = 0; k < n_edits; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                send_event(leb_pkg::M_INSERT, pick_printable(), 8'($urandom_range(0, 255)));
            else if (pick < 42)
                send_event(leb_pkg::M_BKSP, 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
            else if (pick < 54)
                send_event(leb_pkg::M_DELETE, 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
            else if (pick < 63)
                send_event(leb_pkg::M_LEFT, 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
            else if (pick < 72)
                send_event(leb_pkg::M_RIGHT, 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
            else if (pick < 76)
                send_event(leb_pkg::M_HOME, 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
            else if (pick < 80)
                send_event(leb_pkg::M_END, 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
            else if (pick < 92)
                send_event(leb_pkg::M_READ, 8'($urandom_range(0, 255)), pick_index());
            else if (pick < 94)
                send_event(leb_pkg::M_POLL, 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
            else if (pick < 96)
                send_event(leb_pkg::M_LOAD, 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
            else
                // noise: any code at all, spare ones included
                send_event(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
        end
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            send_event(leb_pkg::M_ENTER, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1))
                send_event(leb_pkg::M_POLL, 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
        end else if (pick < 8) begin
            send_event(leb_pkg::M_CANCEL, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
        end else begin
            send_event(leb_pkg::M_STOP, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
        end
        // a few events against the closed buffer, reads still work
        repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(0, 1))
                send_event(leb_pkg::M_READ, 8'($urandom_range(0, 255)), pick_index());
            else
                send_event(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // edge values of every field, every mode but stop and the ignored cases
    task automatic test_directed_edits();
        send_event(leb_pkg::M_POLL,   8'h00, 8'h00);   // nothing submitted yet
        send_event(leb_pkg::M_INSERT, 8'h41, 8'h00);   // inactive, ignored
        send_event(leb_pkg::M_LOAD,   8'h41, 8'hFF);   // inactive, ignored
        send_event(leb_pkg::M_BEGIN,  8'hFF, 8'hFF);
        send_event(leb_pkg::M_LOAD,   8'h00, 8'h00);   // zero byte, ignored
        send_event(leb_pkg::M_LOAD,   8'hFF, 8'h00);
        send_event(leb_pkg::M_LOAD,   8'h01, 8'h00);
        send_event(leb_pkg::M_INSERT, leb_pkg::CH_LOW, 8'h00);
        send_event(leb_pkg::M_INSERT, leb_pkg::CH_HIGH, 8'h00);
        send_event(leb_pkg::M_INSERT, 8'h1F, 8'h00);   // below printable, ignored
        send_event(leb_pkg::M_INSERT, 8'h7F, 8'h00);   // above printable, ignored
        send_event(leb_pkg::M_RIGHT,  8'h00, 8'h00);   // saturates at the end
        send_event(leb_pkg::M_HOME,   8'h00, 8'h00);
        send_event(leb_pkg::M_LEFT,   8'h00, 8'h00);   // saturates at zero
        send_event(leb_pkg::M_BKSP,   8'h00, 8'h00);   // at zero, ignored
        send_event(leb_pkg::M_DELETE, 8'h00, 8'h00);
        send_event(leb_pkg::M_END,    8'h00, 8'h00);
        send_event(leb_pkg::M_DELETE, 8'h00, 8'h00);   // at the end, ignored
        send_event(leb_pkg::M_BKSP,   8'h00, 8'h00);
        send_event(leb_pkg::M_READ,   8'h00, 8'h00);
        send_event(leb_pkg::M_READ,   8'hFF, 8'hFF);   // past the length reads zero
        send_event(MODE_SPARE_A, 8'hAA, 8'h55);
        send_event(MODE_SPARE_B, 8'h55, 8'hAA);
        send_event(leb_pkg::M_ENTER,  8'h00, 8'h00);
        send_event(leb_pkg::M_POLL,   8'h00, 8'h00);   // reports submit then clears
        send_event(leb_pkg::M_POLL,   8'h00, 8'h00);
        send_event(leb_pkg::M_CANCEL, 8'h00, 8'h00);   // inactive, ignored
        wait_drained();
    endtask

    // fill the store to capacity, then long shifts across the full text
    task automatic test_fill_to_capacity();
        send_event(leb_pkg::M_BEGIN, 8'h00, 8'h00);
        while (txt_len < leb_pkg::TEXT_MAX - 1)
            send_event(leb_pkg::M_LOAD, 8'($urandom_range(1, 255)),
                       8'($urandom_range(0, 255)));
        send_event(leb_pkg::M_LOAD,   8'h5A, 8'h00);   // full, ignored
        send_event(leb_pkg::M_INSERT, 8'h41, 8'h00);   // full, ignored
        send_event(leb_pkg::M_READ,   8'h00, 8'h00);
        send_event(leb_pkg::M_READ,   8'h00, 8'(leb_pkg::TEXT_MAX - 2));
        send_event(leb_pkg::M_READ,   8'h00, 8'(leb_pkg::TEXT_MAX - 1));
        send_event(leb_pkg::M_HOME,   8'h00, 8'h00);
        send_event(leb_pkg::M_DELETE, 8'h00, 8'h00);   // whole tail moves left
        send_event(leb_pkg::M_INSERT, 8'h7E, 8'h00);   // whole tail moves right
        send_event(leb_pkg::M_RIGHT,  8'h00, 8'h00);
        send_event(leb_pkg::M_BKSP,   8'h00, 8'h00);
        send_event(leb_pkg::M_INSERT, 8'h20, 8'h00);
        repeat (6) send_event(leb_pkg::M_READ, 8'h00, pick_index());
        send_event(leb_pkg::M_END,    8'h00, 8'h00);
        send_event(leb_pkg::M_BKSP,   8'h00, 8'h00);
        send_event(leb_pkg::M_CANCEL, 8'h00, 8'h00);
        wait_drained();
    endtask

    // bulk random sessions, mostly short texts and a few long ones
    task automatic test_random_sessions();
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        while (events_sent < 1250) begin
            if ($urandom_range(0, 24) == 0)
                run_session(220, $urandom_range(10, 40));
            else
                run_session(20, $urandom_range(5, 40));
        end
        wait_drained();
    endtask

    // sink holds off long enough for the block to stall its input
    task automatic test_output_hold_off();
        sender_gaps   = 1'b0;
        sink_hold_req = 300;
        @(negedge i_clk);
        send_event(leb_pkg::M_BEGIN, 8'h00, 8'h00);
        repeat (12)
            send_event(leb_pkg::M_INSERT,
                       8'($urandom_range(32'(leb_pkg::CH_LOW), 32'(leb_pkg::CH_HIGH))),
                       8'h00);
        send_event(leb_pkg::M_HOME, 8'h00, 8'h00);
        repeat (6) send_event(leb_pkg::M_DELETE, 8'h00, 8'h00);
        repeat (4) send_event(leb_pkg::M_READ, 8'h00, pick_index());
        send_event(leb_pkg::M_ENTER, 8'h00, 8'h00);
        // sender waits here for every status beat before going on
        wait_drained();
        send_event(leb_pkg::M_POLL, 8'h00, 8'h00);
        wait_drained();
    endtask

    // back to back beats with no idling on either side
    task automatic test_steady_stream();
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        repeat (5) run_session(20, 20);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int guard;
        int codes_hit;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = '0;
        s_axis_tdata  = '0;
        sender_gaps   = 1'b0;
        sink_stalls   = 1'b0;
        sink_hold_req = 0;
        mismatches    = 0;
        events_sent   = 0;
        beats_checked = 0;
        peak_len      = 0;
        full_hits     = 0;
        foreach (mode_hits[m]) mode_hits[m] = 0;
        txt_len       = 0;
        txt_cursor    = 0;
        txt_active    = 1'b0;
        txt_submitted = 1'b0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed_edits();
        test_fill_to_capacity();
        test_random_sessions();
        test_output_hold_off();
        test_steady_stream();

        s_axis_tvalid = 1'b0;
        guard = 0;
        while (status_q.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        // anything turning up now has no event behind it
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (status_q.size() != 0) begin
            $display("%0t: %0d status beats never arrived, expected 0 left, actual %0d",
                     $time, status_q.size(), status_q.size());
            mismatches++;
        end

        codes_hit = 0;
        foreach (mode_hits[m]) begin
            if (mode_hits[m] > 0) codes_hit++;
        end
        $display("covered %0d edit events and %0d status beats, %0d of 16 mode codes used",
                 events_sent, beats_checked, codes_hit);
        $display("longest text %0d bytes, store full on %0d events, %0d mismatches",
                 peak_len, full_hits, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
